>>> src/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg: shared types and constants of the Playfair encryption core
// Letter codes, the command format of the front-to-back queue and the
// cell geometry helpers of the 5x5 square.
// ----------------------------------------------------------------------------
package pfe_pkg;

   localparam int LETTER_W = 5;
   localparam int LETTERS = 26;
   localparam int CELLS = 25;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
   localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
   localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;
   localparam logic [LETTER_W-1:0] LETTER_Z = 5'd25;
   localparam logic [LETTER_W-1:0] CELL_COUNT = 5'd25;
   localparam logic [LETTER_W-1:0] LAST_ROW_START = 5'd20;
   localparam logic [2:0] LAST_COL = 3'd4;

   typedef enum logic {
      OP_KEY  = 1'b0,
      OP_PAIR = 1'b1
   } op_type;

   // For OP_KEY, a is the keyword letter and twice requests the fill.
   // For OP_PAIR, a and b form the pair and twice repeats it once more.
   typedef struct packed {
      op_type                op;
      logic [LETTER_W-1:0]   a;
      logic [LETTER_W-1:0]   b;
      logic                  twice;
   } cmd_type;

   typedef struct packed {
      logic                  idle;
      logic [LETTER_W-1:0]   fill_count;
   } status_type;

   function automatic logic [2:0] cell_row(input logic [LETTER_W-1:0] c);
      logic [2:0] r;
      if (c >= 5'd20) begin
         r = 3'd4;
      end else if (c >= 5'd15) begin
         r = 3'd3;
      end else if (c >= 5'd10) begin
         r = 3'd2;
      end else if (c >= 5'd5) begin
         r = 3'd1;
      end else begin
         r = 3'd0;
      end
      return r;
   endfunction

   function automatic logic [LETTER_W-1:0] row_base(input logic [2:0] r);
      return LETTER_W'({r, 2'b00}) + LETTER_W'(r);
   endfunction

   function automatic logic [2:0] cell_col(input logic [LETTER_W-1:0] c);
      logic [LETTER_W-1:0] d;
      d = c - row_base(cell_row(c));
      return d[2:0];
   endfunction

endpackage

>>> src/pfe_front.sv
// ----------------------------------------------------------------------------
// pfe_front: request intake and classification
// Saturates and maps letters, pairs message letters and writes one
// command per request that has work for the back end.
// ----------------------------------------------------------------------------
module pfe_front import pfe_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_func,
   input  logic [LETTER_W-1:0] req_letter,
   input  logic                req_last,
   input  logic                q_full,
   output logic                q_push,
   output cmd_type             q_cmd
);

   logic                pending_valid_ff, pending_valid_in;
   logic [LETTER_W-1:0] pending_letter_ff, pending_letter_in;
   logic                accept;
   logic [LETTER_W-1:0] sat_letter;
   logic [LETTER_W-1:0] msg_letter;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign sat_letter = (req_letter > LETTER_Z) ? LETTER_Z : req_letter;
   assign msg_letter = (sat_letter == LETTER_J) ? LETTER_I : sat_letter;

   always_comb begin
      pending_valid_in  = pending_valid_ff;
      pending_letter_in = pending_letter_ff;
      q_push            = 1'b0;
      q_cmd.op          = OP_PAIR;
      q_cmd.a           = msg_letter;
      q_cmd.b           = LETTER_X;
      q_cmd.twice       = 1'b0;
      if (accept) begin
         if (!req_func) begin
            q_push      = 1'b1;
            q_cmd.op    = OP_KEY;
            q_cmd.a     = sat_letter;
            q_cmd.twice = req_last;
         end else if (pending_valid_ff) begin
            q_push  = 1'b1;
            q_cmd.a = pending_letter_ff;
            if (pending_letter_ff == msg_letter) begin
               // A doubled letter is split by x; at the end the second one
               // also gets x, which repeats the same pair.
               q_cmd.twice = req_last;
               if (req_last) begin
                  pending_valid_in  = 1'b0;
                  pending_letter_in = '0;
               end
            end else begin
               q_cmd.b           = msg_letter;
               pending_valid_in  = 1'b0;
               pending_letter_in = '0;
            end
         end else if (req_last) begin
            q_push = 1'b1;
         end else begin
            pending_valid_in  = 1'b1;
            pending_letter_in = msg_letter;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_valid_ff  <= 1'b0;
         pending_letter_ff <= '0;
      end else begin
         pending_valid_ff  <= pending_valid_in;
         pending_letter_ff <= pending_letter_in;
      end
   end

endmodule

>>> src/pfe_queue.sv
// ----------------------------------------------------------------------------
// pfe_queue: command queue between front and back end
// A small first-in first-out buffer of commands.
// ----------------------------------------------------------------------------
module pfe_queue import pfe_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type             entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> src/pfe_back.sv
// ----------------------------------------------------------------------------
// pfe_back: square builder and pair encryptor
// Places keyword letters, walks the alphabet for the fill, and encrypts
// pairs through the position and square memories into the response port.
// ----------------------------------------------------------------------------
module pfe_back import pfe_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  cmd_type             q_cmd,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [LETTER_W-1:0] rsp_letter,
   output logic                rsp_last,
   output status_type          status
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_FILL = 5'b00010,
      ST_POS  = 5'b00100,
      ST_OUT1 = 5'b01000,
      ST_OUT2 = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [LETTER_W-1:0] fill_ptr_ff, fill_ptr_in;
   logic [LETTER_W-1:0] fill_count_ff, fill_count_in;
   logic [LETTERS-1:0]  used_ff, used_in;
   logic                twice_ff, twice_in;

   logic [LETTER_W-1:0] square_mem [CELLS];
   logic [LETTER_W-1:0] pos_mem [LETTERS];
   logic [LETTER_W-1:0] pos_a_ff, pos_b_ff;
   logic [LETTER_W-1:0] sq_a_ff, sq_b_ff;

   logic                place_en, place_ok;
   logic [LETTER_W-1:0] place_letter;
   logic                pos_rd_en, sq_rd_en;
   logic [LETTER_W-1:0] pa, pb, ra, rb;
   logic [2:0]          row_a, row_b, col_a, col_b;

   always_comb begin
      state_in     = state_ff;
      fill_ptr_in  = fill_ptr_ff;
      twice_in     = twice_ff;
      q_pop        = 1'b0;
      place_en     = 1'b0;
      place_letter = fill_ptr_ff;
      pos_rd_en    = 1'b0;
      sq_rd_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_cmd.op == OP_KEY) begin
                  place_en     = 1'b1;
                  place_letter = q_cmd.a;
                  if (q_cmd.twice) begin
                     fill_ptr_in = '0;
                     state_in    = ST_FILL;
                  end
               end else begin
                  pos_rd_en = 1'b1;
                  twice_in  = q_cmd.twice;
                  state_in  = ST_POS;
               end
            end
         end
         ST_FILL: begin
            place_en    = 1'b1;
            fill_ptr_in = fill_ptr_ff + 1'b1;
            if (fill_ptr_ff == LETTER_Z) begin
               state_in = ST_IDLE;
            end
         end
         ST_POS: begin
            sq_rd_en = 1'b1;
            state_in = ST_OUT1;
         end
         ST_OUT1: begin
            if (rsp_tready) begin
               state_in = ST_OUT2;
            end
         end
         ST_OUT2: begin
            if (rsp_tready) begin
               // The repeated pair has the same letters, so the cipher
               // letters already read are sent a second time.
               if (twice_ff) begin
                  twice_in = 1'b0;
                  state_in = ST_OUT1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign place_ok      = place_en && (fill_count_ff < CELL_COUNT) && !used_ff[place_letter];
   assign used_in       = place_ok ? (used_ff | (LETTERS'(1) << place_letter)) : used_ff;
   assign fill_count_in = fill_count_ff + LETTER_W'(place_ok);

   // Pair rules on the cell indexes of both letters.
   assign pa    = (pos_a_ff < CELL_COUNT) ? pos_a_ff : '0;
   assign pb    = (pos_b_ff < CELL_COUNT) ? pos_b_ff : '0;
   assign row_a = cell_row(pa);
   assign row_b = cell_row(pb);
   assign col_a = cell_col(pa);
   assign col_b = cell_col(pb);

   always_comb begin
      if (row_a == row_b) begin
         ra = (col_a == LAST_COL) ? pa - 5'd4 : pa + 5'd1;
         rb = (col_b == LAST_COL) ? pb - 5'd4 : pb + 5'd1;
      end else if (col_a == col_b) begin
         ra = (pa < LAST_ROW_START) ? pa + 5'd5 : pa - LAST_ROW_START;
         rb = (pb < LAST_ROW_START) ? pb + 5'd5 : pb - LAST_ROW_START;
      end else begin
         ra = row_base(row_a) + LETTER_W'(col_b);
         rb = row_base(row_b) + LETTER_W'(col_a);
      end
   end

   always_ff @(posedge clock) begin
      if (place_ok) begin
         square_mem[fill_count_ff] <= place_letter;
         pos_mem[place_letter]     <= fill_count_ff;
      end
      if (pos_rd_en) begin
         pos_a_ff <= pos_mem[q_cmd.a];
         pos_b_ff <= pos_mem[q_cmd.b];
      end
      if (sq_rd_en) begin
         sq_a_ff <= square_mem[ra];
         sq_b_ff <= square_mem[rb];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ptr_ff   <= '0;
         fill_count_ff <= '0;
         used_ff       <= LETTERS'(1) << LETTER_J;
         twice_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ptr_ff   <= fill_ptr_in;
         fill_count_ff <= fill_count_in;
         used_ff       <= used_in;
         twice_ff      <= twice_in;
      end
   end

   assign rsp_tvalid        = (state_ff == ST_OUT1) || (state_ff == ST_OUT2);
   assign rsp_letter        = (state_ff == ST_OUT2) ? sq_b_ff : sq_a_ff;
   assign rsp_last          = (state_ff == ST_OUT2) && !twice_ff;
   assign status.idle       = (state_ff == ST_IDLE);
   assign status.fill_count = fill_count_ff;

endmodule

>>> src/playfair_cipher_encrypt_core.sv
// ----------------------------------------------------------------------------
// playfair_cipher_encrypt_core: Playfair encryption of letter streams
// Requests on req_* carry keyword letters (tuser 0) or message letters
// (tuser 1), with tlast marking the final letter of the keyword or message.
// Responses on rsp_* carry cipher letters; tlast marks the final letter that
// one request causes. A keyword request gives no response, a message request
// gives zero, two or four cipher letters.
// A front end takes requests and hands commands through a two-entry queue to
// the back end, so requests keep flowing while responses wait. In the back
// end a keyword letter is placed as it is popped, the final keyword letter
// adds the alphabet walk, and an encrypted pair goes through pop with the
// position memory read, square memory read and two output beats, repeated
// for a doubled final letter. With an empty queue and an idle back end, a
// pair's command is registered in the queue, popped and read through both
// memories before the first cipher letter is offered. The next command is
// popped only after the final cipher letter of the current one is sent. Reset
// clears the square, the pairing state and the queue; the whole keyword must
// be sent before the message. A stalled rsp_tready holds the current cipher
// letter and backs up into the queue, then req_tready.
// ----------------------------------------------------------------------------
module playfair_cipher_encrypt_core import pfe_pkg::*; #(
   parameter int QDEPTH = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [4:0] letter, [7:5] zero
   input  logic       req_tuser,   // [0] func
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [4:0] cipher_letter, [7:5] zero
   output logic       rsp_tlast
);

   logic                q_push, q_full, q_pop, q_valid;
   cmd_type             push_cmd, head_cmd;
   status_type          status;
   logic [LETTER_W-1:0] rsp_letter;

   pfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .req_letter (req_tdata[LETTER_W-1:0]),
      .req_last   (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   pfe_queue #(
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (head_cmd)
   );

   pfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (head_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_letter (rsp_letter),
      .rsp_last   (rsp_tlast),
      .status     (status)
   );

   assign rsp_tdata = {3'b000, rsp_letter};

   // The front end never writes a command into a full queue.
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command pushed into full queue");

   // Commands are taken only while the back end is idle and no response waits.
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (status.idle && !rsp_tvalid))
      else $error("command popped while back end busy");

   // The square never holds more than 25 letters.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      status.fill_count <= CELL_COUNT)
      else $error("square fill count out of range");

   // After the final letter of a request the back end returns to idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (!rsp_tvalid && status.idle))
      else $error("response continues after final letter");

endmodule

>>> verif/tb_playfair_cipher_encrypt_core.sv
// ----------------------------------------------------------------------------
// tb_playfair_cipher_encrypt_core: self-checking bench for the Playfair core
// Builds one key square from a keyword and then streams message letters
// through the core. A scripted opening covers keyword repeats, the skipped j,
// saturated letter codes, every pair rule and the padding cases. Random
// letter streams with bursty requests and a stalling receiver follow. Each
// cipher letter is checked against an in-bench model of the square.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_playfair_cipher_encrypt_core import pfe_pkg::*;;

   // Random requests after the scripted opening, about 470 in all.
   localparam int MSG_ITEMS = 446;
   localparam int SQUEEZE_CYCLES = 300;
   localparam int SCRIPT_LEN = 24;

   typedef struct packed {
      logic [LETTER_W-1:0] letter;
      logic                fin;
   } cipher_beat;

   // A quiet row is typed in as causing no response at all.
   typedef struct packed {
      op_type              func;
      logic [LETTER_W-1:0] letter;
      logic                fin;
      logic                quiet;
   } script_row;

   // Keyword "key", j, "word", e again, then code 31 (saturates to z) as the
   // last keyword letter. Square rows: keywo rdzab cfghi lmnpq stuvx.
   localparam script_row SCRIPT [SCRIPT_LEN] = '{
      '{OP_KEY,  5'd10,    1'b0, 1'b1},
      '{OP_KEY,  5'd4,     1'b0, 1'b1},
      '{OP_KEY,  5'd24,    1'b0, 1'b1},
      '{OP_KEY,  LETTER_J, 1'b0, 1'b1},
      '{OP_KEY,  5'd22,    1'b0, 1'b1},
      '{OP_KEY,  5'd14,    1'b0, 1'b1},
      '{OP_KEY,  5'd17,    1'b0, 1'b1},
      '{OP_KEY,  5'd3,     1'b0, 1'b1},
      '{OP_KEY,  5'd4,     1'b0, 1'b1},
      '{OP_KEY,  5'd31,    1'b1, 1'b1},
      '{OP_PAIR, 5'd0,     1'b0, 1'b0},
      '{OP_PAIR, 5'd21,    1'b0, 1'b0},
      '{OP_PAIR, LETTER_X, 1'b0, 1'b0},
      '{OP_PAIR, LETTER_X, 1'b0, 1'b0},
      '{OP_PAIR, LETTER_J, 1'b0, 1'b0},
      '{OP_PAIR, 5'd31,    1'b0, 1'b0},
      '{OP_PAIR, LETTER_Z, 1'b1, 1'b0},
      '{OP_PAIR, 5'd0,     1'b1, 1'b0},
      '{OP_PAIR, 5'd3,     1'b0, 1'b0},
      '{OP_PAIR, 5'd20,    1'b1, 1'b0},
      '{OP_PAIR, 5'd2,     1'b0, 1'b0},
      '{OP_PAIR, 5'd2,     1'b0, 1'b0},
      '{OP_PAIR, 5'd11,    1'b1, 1'b0},
      '{OP_KEY,  5'd5,     1'b1, 1'b1}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [4:0] letter, [7:5] zero
   logic       req_tuser = 1'b0;    // [0] func
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [4:0] cipher_letter, [7:5] zero
   logic       rsp_tlast;

   int error_count = 0;
   bit squeeze_req = 1'b0;
   bit squeeze_on = 1'b0;

   // Model of the key square and the pairing state.
   logic [LETTER_W-1:0] square_at [CELLS];
   int                  cell_of [LETTERS];
   logic [LETTERS-1:0]  placed_marks = LETTERS'(1) << LETTER_J;
   int                  cells_filled = 0;
   logic                half_pair_valid = 1'b0;
   logic [LETTER_W-1:0] half_pair_letter = '0;
   cipher_beat          cipher_due [$];

   playfair_cipher_encrypt_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 200) begin
         $display("%0t mismatch: %s", $time, what);
      end
   endtask

   function automatic void square_place(input int l);
      if (cells_filled >= CELLS || placed_marks[l]) begin
         return;
      end
      square_at[cells_filled] = LETTER_W'(l);
      cell_of[l] = cells_filled;
      placed_marks[l] = 1'b1;
      cells_filled++;
   endfunction

   function automatic void queue_cipher_pair(input logic [LETTER_W-1:0] a,
                                             input logic [LETTER_W-1:0] b,
                                             input logic fin);
      int pa, pb, ca, cb;
      pa = cell_of[a];
      pb = cell_of[b];
      if (pa / 5 == pb / 5) begin
         ca = pa / 5 * 5 + (pa % 5 + 1) % 5;
         cb = pb / 5 * 5 + (pb % 5 + 1) % 5;
      end else if (pa % 5 == pb % 5) begin
         ca = (pa < int'(LAST_ROW_START)) ? pa + 5 : pa - int'(LAST_ROW_START);
         cb = (pb < int'(LAST_ROW_START)) ? pb + 5 : pb - int'(LAST_ROW_START);
      end else begin
         ca = pa / 5 * 5 + pb % 5;
         cb = pb / 5 * 5 + pa % 5;
      end
      cipher_due.push_back('{square_at[ca], 1'b0});
      cipher_due.push_back('{square_at[cb], fin});
   endfunction

   function automatic void encipher_request(input op_type func,
                                            input logic [LETTER_W-1:0] raw,
                                            input logic fin);
      logic [LETTER_W-1:0] l;
      l = (raw > LETTER_Z) ? LETTER_Z : raw;
      if (func == OP_KEY) begin
         square_place(int'(l));
         if (fin) begin
            for (int v = 0; v < LETTERS; v++) begin
               square_place(v);
            end
         end
         return;
      end
      if (l == LETTER_J) begin
         l = LETTER_I;
      end
      if (half_pair_valid) begin
         if (half_pair_letter == l) begin
            // A doubled letter is split with x; the second one waits again
            // unless it ends the message.
            queue_cipher_pair(half_pair_letter, LETTER_X, !fin);
            if (fin) begin
               queue_cipher_pair(l, LETTER_X, 1'b1);
               half_pair_valid = 1'b0;
               half_pair_letter = '0;
            end else begin
               half_pair_letter = l;
            end
         end else begin
            queue_cipher_pair(half_pair_letter, l, 1'b1);
            half_pair_valid = 1'b0;
            half_pair_letter = '0;
         end
      end else if (fin) begin
         queue_cipher_pair(l, LETTER_X, 1'b1);
      end else begin
         half_pair_valid = 1'b1;
         half_pair_letter = l;
      end
   endfunction

   task automatic offer_request(input op_type func, input logic [LETTER_W-1:0] l,
                                input logic fin, input bit quiet);
      int due_before;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, l};
      req_tuser <= func;
      req_tlast <= fin;
      do @(posedge clock); while (!req_tready);
      due_before = cipher_due.size();
      encipher_request(func, l, fin);
      if (quiet) begin
         while (cipher_due.size() > due_before) begin
            void'(cipher_due.pop_back());
         end
      end
   endtask

   function automatic logic [LETTER_W-1:0] pick_message_letter(
         input logic [LETTER_W-1:0] prev);
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         return prev;
      end
      if (r < 22) begin
         return LETTER_J;
      end
      if (r < 30) begin
         return LETTER_W'($urandom_range(26, 31));
      end
      if (r < 35) begin
         return LETTER_X;
      end
      return LETTER_W'($urandom_range(0, 25));
   endfunction

   always @(posedge clock) begin
      cipher_beat want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (cipher_due.size() == 0) begin
            report_mismatch($sformatf("unexpected response letter %0d last %0b",
                                      rsp_tdata[4:0], rsp_tlast));
         end else begin
            want = cipher_due.pop_front();
            if (rsp_tdata[4:0] != want.letter) begin
               report_mismatch($sformatf("cipher letter %0d, expected %0d",
                                         rsp_tdata[4:0], want.letter));
            end
            if (rsp_tlast != want.fin) begin
               report_mismatch($sformatf("response tlast %0b, expected %0b",
                                         rsp_tlast, want.fin));
            end
         end
      end
   end

   // Receiver: changing stall patterns, plus one long hold-off on request.
   initial begin : rsp_side
      int stall_mode;
      int stretch;
      int hold_left;
      bit held;
      stall_mode = 0;
      stretch = 0;
      hold_left = 0;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (squeeze_req && !held) begin
            held = 1'b1;
            hold_left = SQUEEZE_CYCLES;
         end
         squeeze_on = (hold_left > 0);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (stretch == 0) begin
               stall_mode = $urandom_range(0, 3);
               stretch = $urandom_range(10, 60);
            end
            stretch--;
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) == 1);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ~rsp_tready;
            endcase
         end
      end
   end

   initial begin
      #400000;
      $display("tb_playfair_cipher_encrypt_core: errors");
      $finish;
   end

   initial begin : req_side
      int msg_count;
      int burst;
      int gap;
      int wait_cycles;
      logic [LETTER_W-1:0] prev;
      logic [LETTER_W-1:0] l;
      msg_count = 0;
      prev = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < SCRIPT_LEN; i++) begin
         offer_request(SCRIPT[i].func, SCRIPT[i].letter, SCRIPT[i].fin,
                       SCRIPT[i].quiet);
      end

      while (msg_count < MSG_ITEMS) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            // Keyword letters now leave the finished square untouched.
            if ($urandom_range(0, 9) == 0) begin
               offer_request(OP_KEY, LETTER_W'($urandom_range(0, 31)),
                             1'($urandom_range(0, 1)), 1'b0);
            end else begin
               l = pick_message_letter(prev);
               prev = l;
               offer_request(OP_PAIR, l, ($urandom_range(0, 5) == 0), 1'b0);
            end
            msg_count++;
         end
         if (msg_count >= 150) begin
            squeeze_req = 1'b1;
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (!squeeze_on) begin
            repeat (gap) begin
               @(negedge clock);
               req_tvalid <= 1'b0;
            end
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while (cipher_due.size() > 0 && wait_cycles < 4000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (64) @(posedge clock);
      if (cipher_due.size() > 0) begin
         report_mismatch($sformatf("%0d cipher letters never arrived",
                                   cipher_due.size()));
      end

      if (error_count == 0) begin
         $display("tb_playfair_cipher_encrypt_core: clean");
      end else begin
         $display("tb_playfair_cipher_encrypt_core: errors");
      end
      $finish;
   end

endmodule
